/* hw/rtl/ddsm_pkg.sv */
// ----------------------------------------------------------------------------
// Differential drive servo mixer package
// Shared widths, configuration register layout, register indexes and the
// restoring division step used by the duty converters.
// ----------------------------------------------------------------------------
package ddsm_pkg;

    // Command format: signed fixed point with CMD_FRAC_BITS fraction bits.
    localparam int CMD_FRAC_BITS = 14;
    localparam int CMD_W         = 16;
    localparam int CLMP_W        = CMD_FRAC_BITS + 2;
    localparam int EXT_W         = (CLMP_W > CMD_W) ? CLMP_W : CMD_W;
    localparam int SUM_W         = CMD_FRAC_BITS + 3;

    // Speed scale is Q2.8; scaled wheel commands keep eight extra fraction bits.
    localparam int SCALE_W = 10;
    localparam int PROD_W  = SUM_W + SCALE_W + 1;
    localparam int SHIFT   = CMD_FRAC_BITS + 8;
    localparam int WHL_W   = SHIFT + 2;

    // Pulse mapping.
    localparam int PULSE_W = 12;
    localparam int SPAN_W  = PULSE_W + 1;
    localparam int WSP_W   = WHL_W + SPAN_W;
    localparam int X_W     = WSP_W + 1;
    localparam int P_W     = X_W - SHIFT;

    // Duty conversion.
    localparam int DUTY_W     = 16;
    localparam int DVD_W      = PULSE_W + DUTY_W;
    localparam int DIV_STEPS  = 4;
    localparam int DIV_STAGES = DUTY_W / DIV_STEPS;

    // Pipeline stage counts per unit.
    localparam int MIX_STG   = 2;
    localparam int PULSE_STG = 2;
    localparam int DUTY_STG  = 1 + DIV_STAGES;
    localparam int NSTG      = MIX_STG + PULSE_STG + DUTY_STG;

    // Configuration port.
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_SPEED_SCALE    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_MIN_US   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_MID_US   = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_MAX_US   = 8'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LEFT_REVERSED  = 8'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_REVERSED = 8'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DUTY_FULL      = 8'd6;
    localparam logic [CFG_IDX_W-1:0] REG_PWM_PERIOD     = 8'd7;

    typedef struct packed {
        logic [SCALE_W-1:0] speed_scale;
        logic [PULSE_W-1:0] pulse_min_us;
        logic [PULSE_W-1:0] pulse_mid_us;
        logic [PULSE_W-1:0] pulse_max_us;
        logic               left_reversed;
        logic               right_reversed;
        logic [DUTY_W-1:0]  duty_full;
        logic [DUTY_W-1:0]  pwm_period;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        speed_scale:    10'd256,
        pulse_min_us:   12'd1000,
        pulse_mid_us:   12'd1500,
        pulse_max_us:   12'd2000,
        left_reversed:  1'b0,
        right_reversed: 1'b0,
        duty_full:      16'd16383,
        pwm_period:     16'd20000
    };

    typedef logic signed [WHL_W-1:0] whl_t;

    // Partial remainder and the shared dividend/quotient word of the divider.
    typedef struct packed {
        logic [DUTY_W-1:0] rem;
        logic [DUTY_W-1:0] ql;
    } div_t;

    // Clamp a raw command to plus or minus one.
    function automatic logic signed [CLMP_W-1:0] clamp_cmd(input logic signed [CMD_W-1:0] v);
        logic signed [EXT_W-1:0] ext;
        logic signed [EXT_W-1:0] one;
        logic signed [EXT_W-1:0] res;
        ext = EXT_W'(v);
        one = EXT_W'(1) <<< CMD_FRAC_BITS;
        res = ext;
        if (ext > one) begin
            res = one;
        end else if (ext < -one) begin
            res = -one;
        end
        return CLMP_W'(res);
    endfunction

    // One restoring division step: one quotient bit enters at the bottom.
    function automatic div_t div_step(input div_t cur, input logic [DUTY_W-1:0] period);
        logic [DUTY_W:0] trial;
        div_t            nxt;
        trial  = {cur.rem, cur.ql[DUTY_W-1]};
        nxt.ql = {cur.ql[DUTY_W-2:0], 1'b0};
        if (trial >= {1'b0, period}) begin
            trial     = trial - {1'b0, period};
            nxt.ql[0] = 1'b1;
        end
        nxt.rem = trial[DUTY_W-1:0];
        return nxt;
    endfunction

endpackage

/* hw/rtl/ddsm_mix.sv */
// ----------------------------------------------------------------------------
// Command mixer
// Clamps both commands, forms the wheel sums, applies the speed scale with a
// clamp, and negates reversed wheels. Two register stages.
// ----------------------------------------------------------------------------
module ddsm_mix (
    input  logic                                    aclk,
    input  logic [ddsm_pkg::MIX_STG-1:0]            en,
    input  ddsm_pkg::cfg_t                          cfg,
    input  logic signed [ddsm_pkg::CMD_W-1:0]       turn_cmd,
    input  logic signed [ddsm_pkg::CMD_W-1:0]       forward_cmd,
    output ddsm_pkg::whl_t                          left_w,
    output ddsm_pkg::whl_t                          right_w
);
    import ddsm_pkg::*;

    localparam logic signed [PROD_W-1:0] LIM = PROD_W'(1) <<< SHIFT;

    logic signed [CLMP_W-1:0] turn_c;
    logic signed [CLMP_W-1:0] fwd_c;
    logic signed [SUM_W-1:0]  left_sum_reg;
    logic signed [SUM_W-1:0]  right_sum_reg;
    logic signed [PROD_W-1:0] scale_s;
    logic signed [PROD_W-1:0] left_prod;
    logic signed [PROD_W-1:0] right_prod;
    logic signed [PROD_W-1:0] left_clmp;
    logic signed [PROD_W-1:0] right_clmp;
    whl_t                     left_next;
    whl_t                     right_next;
    whl_t                     left_w_reg;
    whl_t                     right_w_reg;

    assign turn_c = clamp_cmd(turn_cmd);
    assign fwd_c  = clamp_cmd(forward_cmd);

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            left_sum_reg  <= SUM_W'(fwd_c) + SUM_W'(turn_c);
            right_sum_reg <= SUM_W'(fwd_c) - SUM_W'(turn_c);
        end
    end

    always_comb begin
        scale_s    = PROD_W'($signed({1'b0, cfg.speed_scale}));
        left_prod  = PROD_W'(left_sum_reg) * scale_s;
        right_prod = PROD_W'(right_sum_reg) * scale_s;

        left_clmp = left_prod;
        if (left_prod > LIM) begin
            left_clmp = LIM;
        end else if (left_prod < -LIM) begin
            left_clmp = -LIM;
        end
        right_clmp = right_prod;
        if (right_prod > LIM) begin
            right_clmp = LIM;
        end else if (right_prod < -LIM) begin
            right_clmp = -LIM;
        end

        left_next  = cfg.left_reversed  ? -WHL_W'(left_clmp)  : WHL_W'(left_clmp);
        right_next = cfg.right_reversed ? -WHL_W'(right_clmp) : WHL_W'(right_clmp);
    end

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            left_w_reg  <= left_next;
            right_w_reg <= right_next;
        end
    end

    assign left_w  = left_w_reg;
    assign right_w = right_w_reg;

endmodule

/* hw/rtl/ddsm_pulse.sv */
// ----------------------------------------------------------------------------
// Wheel pulse mapper
// Maps a scaled wheel command piecewise around the neutral pulse and clamps
// it to the pulse limits. Multiply stage, then add, truncate and clamp stage.
// ----------------------------------------------------------------------------
module ddsm_pulse (
    input  logic                                aclk,
    input  logic [ddsm_pkg::PULSE_STG-1:0]      en,
    input  ddsm_pkg::cfg_t                      cfg,
    input  ddsm_pkg::whl_t                      wheel,
    output logic [ddsm_pkg::PULSE_W-1:0]        pulse
);
    import ddsm_pkg::*;

    localparam logic [X_W-1:0] RND_BIAS = {{(X_W - SHIFT){1'b0}}, {SHIFT{1'b1}}};

    logic signed [SPAN_W-1:0] mid_s;
    logic signed [SPAN_W-1:0] span;
    logic signed [WSP_W-1:0]  prod_reg;
    logic signed [X_W-1:0]    x;
    logic signed [X_W-1:0]    x_adj;
    logic signed [X_W-1:0]    x_sh;
    logic signed [P_W-1:0]    p;
    logic signed [P_W-1:0]    p_min;
    logic signed [P_W-1:0]    p_max;
    logic signed [P_W-1:0]    p_clmp;
    logic [PULSE_W-1:0]       pulse_reg;

    // The upper span applies from neutral upwards, the lower one below it.
    always_comb begin
        mid_s = $signed({1'b0, cfg.pulse_mid_us});
        if (wheel >= 0) begin
            span = $signed({1'b0, cfg.pulse_max_us}) - mid_s;
        end else begin
            span = mid_s - $signed({1'b0, cfg.pulse_min_us});
        end
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            prod_reg <= WSP_W'(wheel) * WSP_W'(span);
        end
    end

    // Truncation toward zero: negative values get a bias before the shift.
    always_comb begin
        x      = (X_W'(mid_s) <<< SHIFT) + X_W'(prod_reg);
        x_adj  = x[X_W-1] ? x + $signed(RND_BIAS) : x;
        x_sh   = x_adj >>> SHIFT;
        p      = x_sh[P_W-1:0];
        p_min  = P_W'($signed({1'b0, cfg.pulse_min_us}));
        p_max  = P_W'($signed({1'b0, cfg.pulse_max_us}));
        p_clmp = p;
        if (p_clmp < p_min) begin
            p_clmp = p_min;
        end
        if (p_clmp > p_max) begin
            p_clmp = p_max;
        end
    end

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            pulse_reg <= p_clmp[PULSE_W-1:0];
        end
    end

    assign pulse = pulse_reg;

endmodule

/* hw/rtl/ddsm_duty.sv */
// ----------------------------------------------------------------------------
// Pulse to duty converter
// Multiplies the pulse by the full duty count and divides by the period with
// a pipelined restoring divider, saturating at the largest duty count.
// ----------------------------------------------------------------------------
module ddsm_duty (
    input  logic                                aclk,
    input  logic [ddsm_pkg::DUTY_STG-1:0]       en,
    input  ddsm_pkg::cfg_t                      cfg,
    input  logic [ddsm_pkg::PULSE_W-1:0]        pulse_in,
    output logic [ddsm_pkg::PULSE_W-1:0]        pulse_out,
    output logic [ddsm_pkg::DUTY_W-1:0]         duty
);
    import ddsm_pkg::*;

    logic [DVD_W-1:0]   dvd_reg;
    logic [PULSE_W-1:0] pls_reg [DIV_STAGES+1];
    div_t               div_reg [DIV_STAGES];
    logic               ovf_reg [DIV_STAGES];

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            dvd_reg    <= DVD_W'(pulse_in) * DVD_W'(cfg.duty_full);
            pls_reg[0] <= pulse_in;
        end
    end

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
        div_t cur_in;
        div_t cur_out;
        logic ovf_in;

        if (k == 0) begin : g_first
            // A quotient above the duty range shows in the upper dividend.
            assign cur_in.rem = DUTY_W'(dvd_reg[DVD_W-1:DUTY_W]);
            assign cur_in.ql  = dvd_reg[DUTY_W-1:0];
            assign ovf_in     = (DUTY_W'(dvd_reg[DVD_W-1:DUTY_W]) >= cfg.pwm_period);
        end else begin : g_next
            assign cur_in = div_reg[k-1];
            assign ovf_in = ovf_reg[k-1];
        end

        always_comb begin
            cur_out = cur_in;
            for (int j = 0; j < DIV_STEPS; j++) begin
                cur_out = div_step(cur_out, cfg.pwm_period);
            end
        end

        always_ff @(posedge aclk) begin
            if (en[k+1]) begin
                div_reg[k]   <= cur_out;
                ovf_reg[k]   <= ovf_in;
                pls_reg[k+1] <= pls_reg[k];
            end
        end
    end

    assign pulse_out = pls_reg[DIV_STAGES];
    assign duty      = ovf_reg[DIV_STAGES-1] ? {DUTY_W{1'b1}} : div_reg[DIV_STAGES-1].ql;

endmodule

/* hw/rtl/differential_drive_servo_mixer.sv */
// ----------------------------------------------------------------------------
// Differential drive servo mixer
// Throughput: one command per cycle while the output is not stalled; the
// nine-stage pipeline (two mixer, two pulse mapping, one duty multiply and
// four divider stages) sets the latency.
// Reset: aresetn is synchronous and active low; it empties the pipeline and
// returns every configuration register to its documented default.
// ----------------------------------------------------------------------------
module differential_drive_servo_mixer (
    input  logic                                aclk,
    input  logic                                aresetn,

    // Command input. s_tdata: turn_cmd [15:0], forward_cmd [31:16].
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [31:0]                         s_tdata,

    // Result output. m_tdata: left_pulse_us [11:0], right_pulse_us [23:12],
    // left_duty [39:24], right_duty [55:40].
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [55:0]                         m_tdata,

    // Configuration writes: index selects the register, data is its value.
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ddsm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ddsm_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import ddsm_pkg::*;

    // Stage slices along the pipeline.
    localparam int PULSE_LO = MIX_STG;
    localparam int DUTY_LO  = MIX_STG + PULSE_STG;

    cfg_t               cfg_reg;
    logic [NSTG-1:0]    valid_reg;
    logic [NSTG-1:0]    valid_next;
    logic [NSTG-1:0]    en;

    whl_t               left_w;
    whl_t               right_w;
    logic [PULSE_W-1:0] left_pulse;
    logic [PULSE_W-1:0] right_pulse;
    logic [PULSE_W-1:0] left_pulse_out;
    logic [PULSE_W-1:0] right_pulse_out;
    logic [DUTY_W-1:0]  left_duty;
    logic [DUTY_W-1:0]  right_duty;

    // ------------------------------------------------------------------------
    // Configuration registers. Writes are always taken; an index beyond the
    // register list is ignored. Writes are only expected while the pipeline
    // is empty, so the stages read the registers directly.
    // ------------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_SPEED_SCALE:    cfg_reg.speed_scale    <= cfg_data[SCALE_W-1:0];
                REG_PULSE_MIN_US:   cfg_reg.pulse_min_us   <= cfg_data[PULSE_W-1:0];
                REG_PULSE_MID_US:   cfg_reg.pulse_mid_us   <= cfg_data[PULSE_W-1:0];
                REG_PULSE_MAX_US:   cfg_reg.pulse_max_us   <= cfg_data[PULSE_W-1:0];
                REG_LEFT_REVERSED:  cfg_reg.left_reversed  <= cfg_data[0];
                REG_RIGHT_REVERSED: cfg_reg.right_reversed <= cfg_data[0];
                REG_DUTY_FULL:      cfg_reg.duty_full      <= cfg_data[DUTY_W-1:0];
                REG_PWM_PERIOD:     cfg_reg.pwm_period     <= cfg_data[DUTY_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Pipeline flow control. Each stage loads when it is empty or when the
    // stage after it loads in the same cycle, so bubbles close up and a
    // stalled output only holds back the stages that are actually full. The
    // input side is ready whenever the first stage can load.
    // ------------------------------------------------------------------------
    always_comb begin
        en[NSTG-1] = !valid_reg[NSTG-1] || m_tready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            en[k] = !valid_reg[k] || en[k+1];
        end
        valid_next[0] = en[0] ? s_tvalid : valid_reg[0];
        for (int k = 1; k < NSTG; k++) begin
            valid_next[k] = en[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_tready = en[0];
    assign m_tvalid = valid_reg[NSTG-1];

    // ------------------------------------------------------------------------
    // Datapath: mixer for both wheels, then one pulse mapper and one duty
    // converter per wheel.
    // ------------------------------------------------------------------------
    ddsm_mix u_mix (
        .aclk        (aclk),
        .en          (en[MIX_STG-1:0]),
        .cfg         (cfg_reg),
        .turn_cmd    ($signed(s_tdata[15:0])),
        .forward_cmd ($signed(s_tdata[31:16])),
        .left_w      (left_w),
        .right_w     (right_w)
    );

    ddsm_pulse u_pulse_left (
        .aclk  (aclk),
        .en    (en[DUTY_LO-1:PULSE_LO]),
        .cfg   (cfg_reg),
        .wheel (left_w),
        .pulse (left_pulse)
    );

    ddsm_pulse u_pulse_right (
        .aclk  (aclk),
        .en    (en[DUTY_LO-1:PULSE_LO]),
        .cfg   (cfg_reg),
        .wheel (right_w),
        .pulse (right_pulse)
    );

    ddsm_duty u_duty_left (
        .aclk      (aclk),
        .en        (en[NSTG-1:DUTY_LO]),
        .cfg       (cfg_reg),
        .pulse_in  (left_pulse),
        .pulse_out (left_pulse_out),
        .duty      (left_duty)
    );

    ddsm_duty u_duty_right (
        .aclk      (aclk),
        .en        (en[NSTG-1:DUTY_LO]),
        .cfg       (cfg_reg),
        .pulse_in  (right_pulse),
        .pulse_out (right_pulse_out),
        .duty      (right_duty)
    );

    // The four fields fill exactly seven bytes, so no padding is needed.
    assign m_tdata = {right_duty, left_duty, right_pulse_out, left_pulse_out};

    // ------------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------------

    // With no result waiting, nothing can hold back the input side.
    a_ready_when_out_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled while output stage empty");

    // A transfer on the input side always lands in the first stage.
    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> valid_reg[0])
        else $error("accepted command lost at pipeline entry");

    // An empty pipeline cannot present a result in the following cycle.
    a_no_invented_result: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg == '0 |=> !m_tvalid)
        else $error("result appeared from an empty pipeline");

endmodule

/* tb/differential_drive_servo_mixer_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Differential drive servo mixer testbench
// Sends turn and forward commands through the stream ports and reprograms the
// servo and PWM registers between traffic phases. Every result is compared
// with a hand-written value or a behavioural model of the mixer in this bench.
// ----------------------------------------------------------------------------
module differential_drive_servo_mixer_tb;
    import ddsm_pkg::*;

    // Depth of the block's pipeline, as given in its header.
    localparam int     PIPE_DEPTH      = 9;
    localparam int     WHEEL_FRAC      = CMD_FRAC_BITS + 8;
    localparam longint CMD_ONE         = longint'(1) <<< CMD_FRAC_BITS;
    localparam longint WHEEL_LIM       = CMD_ONE <<< 8;
    localparam int     PHASES          = 10;
    localparam int     ITEMS_PER_PHASE = 200;
    localparam int     REPORT_LIMIT    = 10;

    // Command values worth hitting on purpose: both saturation edges, the
    // values just beyond them and the raw extremes of the 16-bit field.
    localparam logic [15:0] CMD_FULL_POS = 16'h4000;
    localparam logic [15:0] CMD_FULL_NEG = 16'hC000;
    localparam logic [15:0] CMD_RAW_MAX  = 16'h7FFF;
    localparam logic [15:0] CMD_RAW_MIN  = 16'h8000;
    localparam logic [15:0] CMD_EDGES [9] = '{
        16'h8000, 16'hBFFF, 16'hC000, 16'hFFFF, 16'h0000,
        16'h0001, 16'h4000, 16'h4001, 16'h7FFF
    };

    // One result as it sits on m_tdata; the first member takes the top bits.
    typedef struct packed {
        logic [15:0] right_duty;
        logic [15:0] left_duty;
        logic [11:0] right_pulse;
        logic [11:0] left_pulse;
    } servo_out_t;

    typedef enum logic { ROW_REG, ROW_CMD } row_kind_t;

    // One line of the directed table: either a register write or a command,
    // the latter optionally with its result written out by hand.
    typedef struct {
        row_kind_t   kind;
        logic [7:0]  idx;
        logic [15:0] val;
        logic [15:0] turn;
        logic [15:0] fwd;
        bit          known;
        servo_out_t  want;
    } bench_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;    // turn_cmd [15:0], forward_cmd [31:16]
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;    // left_pulse_us, right_pulse_us, left_duty, right_duty
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_index;
    logic [15:0] cfg_data;

    // Register image held by the bench, at the widths of the block.
    logic [9:0]  scale_q8;
    logic [11:0] min_us;
    logic [11:0] mid_us;
    logic [11:0] max_us;
    logic        rev_left;
    logic        rev_right;
    logic [15:0] duty_full_cnt;
    logic [15:0] period_cnt;

    // Wheel results still owed by the block, oldest first.
    servo_out_t expected_wheels[$];

    int fail_count;
    int src_idle_pct;
    int sink_stall_pct;

    differential_drive_servo_mixer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 50 MHz clock.
    initial begin : clock_gen
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Behavioural model of the mixer
    // ------------------------------------------------------------------------

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        if (v < lo) begin
            return lo;
        end
        if (v > hi) begin
            return hi;
        end
        return v;
    endfunction

    // The wheel command carries 22 fraction bits. It moves the pulse away from
    // neutral by the upper or the lower span, and the sum is truncated toward
    // zero. The minimum clamp goes first, so crossed limits end at the maximum.
    function automatic logic [11:0] wheel_to_pulse(input longint w);
        longint mid;
        longint span;
        longint x;
        longint p;
        mid  = longint'(mid_us);
        span = (w >= 0) ? longint'(max_us) - mid : mid - longint'(min_us);
        x    = (mid <<< WHEEL_FRAC) + w * span;
        p    = (x >= 0) ? (x >>> WHEEL_FRAC) : -((-x) >>> WHEEL_FRAC);
        if (p < longint'(min_us)) begin
            p = longint'(min_us);
        end
        if (p > longint'(max_us)) begin
            p = longint'(max_us);
        end
        return p[11:0];
    endfunction

    // A zero period saturates the duty, as does any quotient beyond 16 bits.
    function automatic logic [15:0] pulse_to_duty_count(input logic [11:0] pulse);
        longint q;
        if (period_cnt == '0) begin
            return 16'hFFFF;
        end
        q = longint'(pulse) * longint'(duty_full_cnt) / longint'(period_cnt);
        return (q > 65535) ? 16'hFFFF : q[15:0];
    endfunction

    function automatic servo_out_t mix_wheels(input logic [15:0] turn_raw,
                                              input logic [15:0] fwd_raw);
        longint     t;
        longint     f;
        longint     l;
        longint     r;
        servo_out_t o;
        t = clip(longint'($signed(turn_raw)), -CMD_ONE, CMD_ONE);
        f = clip(longint'($signed(fwd_raw)), -CMD_ONE, CMD_ONE);
        l = clip((f + t) * longint'(scale_q8), -WHEEL_LIM, WHEEL_LIM);
        r = clip((f - t) * longint'(scale_q8), -WHEEL_LIM, WHEEL_LIM);
        if (rev_left) begin
            l = -l;
        end
        if (rev_right) begin
            r = -r;
        end
        o.left_pulse  = wheel_to_pulse(l);
        o.right_pulse = wheel_to_pulse(r);
        o.left_duty   = pulse_to_duty_count(o.left_pulse);
        o.right_duty  = pulse_to_duty_count(o.right_pulse);
        return o;
    endfunction

    // ------------------------------------------------------------------------
    // Directed table helpers
    // ------------------------------------------------------------------------

    function automatic bench_row_t reg_row(input logic [7:0] idx, input logic [15:0] val);
        bench_row_t r;
        r.kind  = ROW_REG;
        r.idx   = idx;
        r.val   = val;
        r.turn  = '0;
        r.fwd   = '0;
        r.known = 1'b0;
        r.want  = '0;
        return r;
    endfunction

    function automatic bench_row_t cmd_row(input logic [15:0] turn, input logic [15:0] fwd);
        bench_row_t r;
        r       = reg_row('0, '0);
        r.kind  = ROW_CMD;
        r.turn  = turn;
        r.fwd   = fwd;
        return r;
    endfunction

    function automatic bench_row_t known_row(input logic [15:0] turn, input logic [15:0] fwd,
                                             input logic [11:0] lp, input logic [11:0] rp,
                                             input logic [15:0] ld, input logic [15:0] rd);
        bench_row_t r;
        r                  = cmd_row(turn, fwd);
        r.known            = 1'b1;
        r.want.left_pulse  = lp;
        r.want.right_pulse = rp;
        r.want.left_duty   = ld;
        r.want.right_duty  = rd;
        return r;
    endfunction

    // Mostly commands inside the legal range, with a share of raw 16-bit
    // values and of values sitting right on or just past the clamp points.
    function automatic logic [15:0] pick_cmd();
        int v;
        case ($urandom_range(0, 3))
            0: begin
                return 16'($urandom);
            end
            1, 2: begin
                v = int'($urandom_range(0, 32768)) - 16384;
                return v[15:0];
            end
            default: begin
                return CMD_EDGES[$urandom_range(0, 8)];
            end
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Bus drivers
    // ------------------------------------------------------------------------

    // Offers one command and waits for its transfer. The valid stays high on
    // return, so a following command can go out back to back; every caller
    // enters and leaves at a falling edge.
    task automatic send_command(input logic [15:0] turn, input logic [15:0] fwd,
                                input bit known, input servo_out_t want);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {fwd, turn};
        do @(posedge aclk); while (!s_tready);
        expected_wheels.push_back(known ? want : mix_wheels(turn, fwd));
        @(negedge aclk);
    endtask

    // Writes one register and mirrors it into the model. The valid is left
    // high; the caller lowers it once the batch of writes is done.
    task automatic write_reg(input logic [7:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_SPEED_SCALE:    scale_q8      = val[9:0];
            REG_PULSE_MIN_US:   min_us        = val[11:0];
            REG_PULSE_MID_US:   mid_us        = val[11:0];
            REG_PULSE_MAX_US:   max_us        = val[11:0];
            REG_LEFT_REVERSED:  rev_left      = val[0];
            REG_RIGHT_REVERSED: rev_right     = val[0];
            REG_DUTY_FULL:      duty_full_cnt = val;
            REG_PWM_PERIOD:     period_cnt    = val;
            default: ;
        endcase
        @(negedge aclk);
    endtask

    // Holds the sender back until every owed result has come out, then lets
    // the pipeline run empty before anything else happens.
    task automatic settle_pipeline();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (expected_wheels.size() != 0) begin
            @(negedge aclk);
        end
        repeat (PIPE_DEPTH) @(negedge aclk);
    endtask

    // Loads a whole register set. Kind 0 is the power-on set, 1 and 2 the top
    // and bottom extremes, 3 a plausible servo set and 4 raw random words,
    // which also exercise the bits above each register's width. Each set ends
    // with a write to an unused index, which must leave everything unchanged.
    task automatic program_setting(input int kind);
        logic [15:0] v_scale;
        logic [15:0] v_min;
        logic [15:0] v_mid;
        logic [15:0] v_max;
        logic [15:0] v_revl;
        logic [15:0] v_revr;
        logic [15:0] v_duty;
        logic [15:0] v_period;
        case (kind)
            0: begin
                v_scale = 16'd256;  v_min  = 16'd1000; v_mid  = 16'd1500;
                v_max   = 16'd2000; v_revl = 16'd0;    v_revr = 16'd0;
                v_duty  = 16'd16383; v_period = 16'd20000;
            end
            1: begin
                v_scale = 16'd1023; v_min  = 16'd4095; v_mid  = 16'd4095;
                v_max   = 16'd4095; v_revl = 16'd1;    v_revr = 16'd1;
                v_duty  = 16'hFFFF; v_period = 16'hFFFF;
            end
            2: begin
                v_scale = '0; v_min = '0; v_mid  = '0; v_max    = '0;
                v_revl  = '0; v_revr = '0; v_duty = '0; v_period = '0;
            end
            3: begin
                v_min    = 16'($urandom_range(500, 1200));
                v_mid    = v_min + 16'($urandom_range(0, 600));
                v_max    = v_mid + 16'($urandom_range(0, 900));
                v_scale  = 16'($urandom_range(0, 600));
                v_revl   = 16'($urandom_range(0, 1));
                v_revr   = 16'($urandom_range(0, 1));
                v_duty   = 16'($urandom_range(1, 65535));
                v_period = 16'($urandom_range(1000, 40000));
            end
            default: begin
                v_scale = 16'($urandom); v_min  = 16'($urandom); v_mid  = 16'($urandom);
                v_max   = 16'($urandom); v_revl = 16'($urandom); v_revr = 16'($urandom);
                v_duty  = 16'($urandom); v_period = 16'($urandom);
            end
        endcase
        write_reg(REG_SPEED_SCALE,    v_scale);
        write_reg(REG_PULSE_MIN_US,   v_min);
        write_reg(REG_PULSE_MID_US,   v_mid);
        write_reg(REG_PULSE_MAX_US,   v_max);
        write_reg(REG_LEFT_REVERSED,  v_revl);
        write_reg(REG_RIGHT_REVERSED, v_revr);
        write_reg(REG_DUTY_FULL,      v_duty);
        write_reg(REG_PWM_PERIOD,     v_period);
        write_reg(8'($urandom_range(int'(REG_PWM_PERIOD) + 1, 255)), 16'($urandom));
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------

    function automatic void note_failure(input string msg);
        fail_count++;
        if (fail_count <= REPORT_LIMIT) begin
            $display("%0t ns: %s", $time, msg);
        end
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want) begin
            note_failure($sformatf("%s mismatch: expected %0d, got %0d", name, want, got));
        end
    endfunction

    // Every result transfer is matched against the oldest owed result.
    always @(posedge aclk) begin : result_check
        servo_out_t got;
        servo_out_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (expected_wheels.size() == 0) begin
                note_failure($sformatf("unexpected result transfer, data %h", m_tdata));
            end else begin
                want = expected_wheels.pop_front();
                check_field("left pulse",  16'(want.left_pulse),  16'(got.left_pulse));
                check_field("right pulse", 16'(want.right_pulse), 16'(got.right_pulse));
                check_field("left duty",   want.left_duty,        got.left_duty);
                check_field("right duty",  want.right_duty,       got.right_duty);
            end
        end
    end

    // Receiver: stalls at random at the rate the current phase asks for.
    initial begin : result_sink
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    // Watchdog. The slowest legal run is well under a tenth of this.
    initial begin : watchdog
        #20ms;
        $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------

    initial begin : stimulus
        bench_row_t rows[$];
        servo_out_t none;
        bit         prev_reg;
        int         phase;
        int         n;

        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        fail_count     = 0;
        none           = '0;

        // Power-on register values.
        scale_q8      = 10'd256;
        min_us        = 12'd1000;
        mid_us        = 12'd1500;
        max_us        = 12'd2000;
        rev_left      = 1'b0;
        rev_right     = 1'b0;
        duty_full_cnt = 16'd16383;
        period_cnt    = 16'd20000;

        // Directed table. With the reset registers neutral is 1500 us and the
        // full swing reaches 1000 and 2000 us; 1500, 2000 and 1000 us give
        // duties of 1228, 1638 and 819 counts.
        rows.push_back(known_row('0, '0, 12'd1500, 12'd1500, 16'd1228, 16'd1228));
        rows.push_back(known_row('0, CMD_FULL_POS, 12'd2000, 12'd2000, 16'd1638, 16'd1638));
        rows.push_back(known_row('0, CMD_FULL_NEG, 12'd1000, 12'd1000, 16'd819, 16'd819));
        rows.push_back(known_row(CMD_FULL_POS, '0, 12'd2000, 12'd1000, 16'd1638, 16'd819));
        // Raw extremes beyond one are clamped before mixing.
        rows.push_back(known_row(CMD_RAW_MAX, CMD_RAW_MAX,
                                 12'd2000, 12'd1500, 16'd1638, 16'd1228));
        rows.push_back(known_row(CMD_RAW_MIN, CMD_RAW_MIN,
                                 12'd1000, 12'd1500, 16'd819, 16'd1228));
        rows.push_back(known_row(CMD_RAW_MIN, CMD_RAW_MAX,
                                 12'd1500, 12'd2000, 16'd1228, 16'd1638));
        rows.push_back(cmd_row(16'd8192, 16'd4096));
        // Both wheels mirrored, then only the right one.
        rows.push_back(reg_row(REG_LEFT_REVERSED, 16'd1));
        rows.push_back(reg_row(REG_RIGHT_REVERSED, 16'd1));
        rows.push_back(known_row('0, CMD_FULL_POS, 12'd1000, 12'd1000, 16'd819, 16'd819));
        rows.push_back(reg_row(REG_LEFT_REVERSED, 16'd0));
        rows.push_back(cmd_row(16'hF000, 16'd3000));
        rows.push_back(reg_row(REG_RIGHT_REVERSED, 16'd0));
        // A zero scale holds both wheels at neutral.
        rows.push_back(reg_row(REG_SPEED_SCALE, 16'd0));
        rows.push_back(known_row(CMD_FULL_POS, CMD_FULL_POS,
                                 12'd1500, 12'd1500, 16'd1228, 16'd1228));
        // A scale above two is still bounded by the clamp after mixing.
        rows.push_back(reg_row(REG_SPEED_SCALE, 16'd1023));
        rows.push_back(cmd_row(16'd100, 16'd50));
        rows.push_back(known_row(CMD_FULL_NEG, CMD_FULL_POS,
                                 12'd1500, 12'd2000, 16'd1228, 16'd1638));
        rows.push_back(reg_row(REG_SPEED_SCALE, 16'd128));
        rows.push_back(cmd_row(16'd4000, 16'hF448));
        // Crossed pulse limits: the maximum wins whatever the command.
        rows.push_back(reg_row(REG_PULSE_MIN_US, 16'd2500));
        rows.push_back(reg_row(REG_PULSE_MID_US, 16'd1800));
        rows.push_back(reg_row(REG_PULSE_MAX_US, 16'd1200));
        rows.push_back(known_row('0, '0, 12'd1200, 12'd1200, 16'd982, 16'd982));
        rows.push_back(cmd_row(16'd10000, 16'hEC78));
        // A zero period saturates the duty.
        rows.push_back(reg_row(REG_PWM_PERIOD, 16'd0));
        rows.push_back(known_row('0, '0, 12'd1200, 12'd1200, 16'hFFFF, 16'hFFFF));
        // Widest pulse range at unit scale with a one-microsecond period.
        rows.push_back(reg_row(REG_SPEED_SCALE, 16'd256));
        rows.push_back(reg_row(REG_PULSE_MIN_US, 16'd0));
        rows.push_back(reg_row(REG_PULSE_MID_US, 16'd0));
        rows.push_back(reg_row(REG_PULSE_MAX_US, 16'd4095));
        rows.push_back(reg_row(REG_PWM_PERIOD, 16'd1));
        rows.push_back(reg_row(REG_DUTY_FULL, 16'hFFFF));
        rows.push_back(known_row('0, CMD_FULL_POS, 12'd4095, 12'd4095, 16'hFFFF, 16'hFFFF));
        rows.push_back(known_row('0, CMD_FULL_NEG, 12'd0, 12'd0, 16'd0, 16'd0));
        rows.push_back(reg_row(REG_DUTY_FULL, 16'd0));
        rows.push_back(known_row('0, CMD_FULL_POS, 12'd4095, 12'd4095, 16'd0, 16'd0));
        // Writes to unused indexes must not disturb any register.
        rows.push_back(reg_row(8'(int'(REG_PWM_PERIOD) + 1), 16'hFFFF));
        rows.push_back(reg_row(8'hFF, 16'h0000));
        rows.push_back(known_row('0, CMD_FULL_POS, 12'd4095, 12'd4095, 16'd0, 16'd0));
        rows.push_back(cmd_row(16'd123, 16'hFE38));

        // Synchronous reset, released at a falling edge.
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Registers are only written with the pipeline empty.
        prev_reg = 1'b0;
        foreach (rows[i]) begin
            if (rows[i].kind == ROW_REG) begin
                if (!prev_reg) begin
                    settle_pipeline();
                end
                write_reg(rows[i].idx, rows[i].val);
                prev_reg = 1'b1;
            end else begin
                if (prev_reg) begin
                    cfg_valid <= 1'b0;
                end
                send_command(rows[i].turn, rows[i].fwd, rows[i].known, rows[i].want);
                prev_reg = 1'b0;
            end
        end

        // Random phases. Each one drains the pipeline, loads a fresh register
        // set and then streams commands under one of four idling patterns.
        for (phase = 0; phase < PHASES; phase++) begin
            settle_pipeline();
            case (phase % 4)
                0: begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 0;
                end
                1: begin
                    src_idle_pct   = 76;
                    sink_stall_pct = 0;
                end
                2: begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 76;
                end
                default: begin
                    src_idle_pct   = 36;
                    sink_stall_pct = 36;
                end
            endcase
            program_setting(phase % 5);
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                // Now and then the sender waits for every owed result.
                if ($urandom_range(0, 149) == 0) begin
                    settle_pipeline();
                end
                send_command(pick_cmd(), pick_cmd(), 1'b0, none);
            end
        end

        // Wait for the last results, then give the pipeline time to show
        // any stray transfer.
        settle_pipeline();
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
